@@ rtl/ctl_pkg.sv @@
// Package for the C-style token lexer: payload structs, lexer state codes,
// token kind codes, character codes and small helper functions.
// No dependencies.
package ctl_pkg;

  // Input item: one source byte and the end-of-source mark
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } char_item_t;

  // Result item: one token record
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_row;
    logic [15:0] token_col;
    logic [15:0] token_length;
    logic        last;
  } token_t;

  // Token kinds
  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_DEC   = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_CHR   = 3'd3;
  localparam logic [2:0] KIND_ID    = 3'd4;
  localparam logic [2:0] KIND_SIGN  = 3'd5;
  localparam logic [2:0] KIND_UNDEF = 3'd6;
  localparam logic [2:0] KIND_END   = 3'd7;

  // Recogniser states
  typedef enum logic [4:0] {
    ST_START      = 5'd0,
    ST_SLASH      = 5'd1,
    ST_BLOCK      = 5'd2,
    ST_LINE       = 5'd3,
    ST_BLOCK_STAR = 5'd4,
    ST_EQ         = 5'd5,
    ST_ID         = 5'd6,
    ST_INT        = 5'd7,
    ST_DEC        = 5'd8,
    ST_LT         = 5'd9,
    ST_GT         = 5'd10,
    ST_NOT        = 5'd11,
    ST_ADD        = 5'd12,
    ST_SUB        = 5'd13,
    ST_AND        = 5'd14,
    ST_OR         = 5'd15,
    ST_STR        = 5'd16,
    ST_CHR        = 5'd17,
    ST_CHR_END    = 5'd18,
    ST_MUL        = 5'd19
  } lex_state_t;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Result queue depth
  localparam int QDEPTH = 4;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

endpackage

@@ rtl/ctl_stream_if.sv @@
// Valid/ready stream interface used by both lexer channels.
// Payload type is a parameter; types come from ctl_pkg.
interface ctl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/c_style_token_lexer.sv @@
// C-style token lexer top level: recogniser state, counters and result queue.
// Depends on ctl_pkg and ctl_stream_if.
//
// Usage:
//   src carries one source byte per transfer (ch, end_of_input); tok carries
//   one token record per transfer (kind, row, start column, length, last).
//   The recogniser step and counter update are combinational and sit
//   between the state registers and a four-entry result queue. A byte can
//   produce up to two records, which are written to the queue together at
//   the byte's transfer and leave it on tok in order.
//   src accepts a byte in every cycle while the queue has room for two
//   records, so the rate is one byte per cycle as long as tok drains one
//   record per cycle; bytes yielding two records each need two tok transfers.
//   When tok stalls the queue fills and src.ready drops once fewer than two
//   entries are free; nothing is lost. Reset (rst, synchronous) empties the
//   queue and returns row, column, token start and length to zero and the
//   recogniser to its start state. An end-of-source byte emits an end record
//   and performs the same return to reset values, so a new source can follow.
module c_style_token_lexer (
  input logic clk,
  input logic rst,
  ctl_stream_if.sink   src,
  ctl_stream_if.source tok
);
  import ctl_pkg::*;

  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int FILL_W = $clog2(QDEPTH + 1);

  // Recogniser state and counters
  lex_state_t  lex_state, lex_state_next;
  logic [15:0] line_count, line_count_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] start_column, start_column_next;
  logic [15:0] text_length, text_length_next;

  // Result queue
  token_t             queue [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;

  // Records from the current byte: first from the token in progress,
  // second from the byte examined as a token start
  logic   ea_v, eb_v, redo;
  token_t ea, eb;
  logic [7:0] c;
  logic   accept, pop;
  logic [1:0] push_n;

  assign accept = src.valid && src.ready;
  assign pop    = tok.valid && tok.ready;
  assign src.ready = fill <= FILL_W'(QDEPTH - 2);
  assign tok.valid = fill != '0;
  assign tok.data  = queue[rd_ptr];
  assign c = src.data.ch;

  // Recogniser step for the byte on src
  always_comb begin
    lex_state_next    = lex_state;
    line_count_next   = line_count;
    column_count_next = column_count;
    start_column_next = start_column;
    text_length_next  = text_length;
    ea_v = 1'b0;
    eb_v = 1'b0;
    ea   = '0;
    eb   = '0;
    redo = 1'b0;
    if (src.data.end_of_input) begin
      ea_v = 1'b1;
      ea.token_kind   = KIND_END;
      ea.token_row    = line_count;
      ea.token_col    = column_count;
      ea.token_length = '0;
      lex_state_next    = ST_START;
      line_count_next   = '0;
      column_count_next = '0;
      start_column_next = '0;
      text_length_next  = '0;
    end else begin
      column_count_next = sat_inc(column_count);
      ea.token_row = line_count;
      ea.token_col = start_column;
      ea.token_length = text_length;

      // Continue the token in progress
      unique case (lex_state)
        ST_SLASH: begin
          if (c == CH_STAR) begin
            lex_state_next = ST_BLOCK;
          end else if (c == CH_SLASH) begin
            lex_state_next = ST_LINE;
          end else if (c == CH_EQ) begin
            ea_v = 1'b1; ea.token_kind = KIND_SIGN;
            text_length_next = sat_inc(text_length);
            ea.token_length = text_length_next;
            lex_state_next = ST_START;
          end else begin
            ea_v = 1'b1; ea.token_kind = KIND_SIGN; redo = 1'b1;
          end
        end
        ST_BLOCK: begin
          if (c == CH_STAR) lex_state_next = ST_BLOCK_STAR;
        end
        ST_LINE: begin
          if (c == CH_NL) redo = 1'b1;
        end
        ST_BLOCK_STAR: begin
          if (c == CH_SLASH) lex_state_next = ST_START;
          else if (c != CH_STAR) lex_state_next = ST_BLOCK;
        end
        ST_EQ, ST_LT, ST_GT, ST_NOT, ST_MUL, ST_ADD, ST_SUB, ST_AND, ST_OR: begin
          if ((c == CH_EQ && lex_state != ST_SUB && lex_state != ST_AND &&
               lex_state != ST_OR) ||
              (lex_state == ST_EQ && (c == CH_GT || c == CH_LT)) ||
              (lex_state == ST_ADD && c == CH_PLUS) ||
              (lex_state == ST_SUB && c == CH_MINUS) ||
              (lex_state == ST_AND && c == CH_AMP) ||
              (lex_state == ST_OR && c == CH_BAR)) begin
            ea_v = 1'b1; ea.token_kind = KIND_SIGN;
            text_length_next = sat_inc(text_length);
            ea.token_length = text_length_next;
            lex_state_next = ST_START;
          end else begin
            ea_v = 1'b1; redo = 1'b1;
            ea.token_kind = (lex_state == ST_AND || lex_state == ST_OR) ?
                            KIND_UNDEF : KIND_SIGN;
          end
        end
        ST_ID: begin
          if (is_digit(c) || is_alpha(c)) begin
            text_length_next = sat_inc(text_length);
          end else begin
            ea_v = 1'b1; ea.token_kind = KIND_ID; redo = 1'b1;
          end
        end
        ST_INT: begin
          if (is_digit(c)) begin
            text_length_next = sat_inc(text_length);
          end else if (c == CH_DOT) begin
            text_length_next = sat_inc(text_length);
            lex_state_next = ST_DEC;
          end else begin
            ea_v = 1'b1; ea.token_kind = KIND_INT; redo = 1'b1;
          end
        end
        ST_DEC: begin
          if (is_digit(c)) begin
            text_length_next = sat_inc(text_length);
          end else begin
            ea_v = 1'b1; ea.token_kind = KIND_DEC; redo = 1'b1;
          end
        end
        ST_STR: begin
          if (c == CH_DQUOTE) begin
            ea_v = 1'b1; ea.token_kind = KIND_STR;
            lex_state_next = ST_START;
          end else begin
            text_length_next = sat_inc(text_length);
          end
        end
        ST_CHR: begin
          if (c == CH_NL) begin
            ea_v = 1'b1; ea.token_kind = KIND_UNDEF; redo = 1'b1;
          end else begin
            text_length_next = sat_inc(text_length);
            lex_state_next = ST_CHR_END;
          end
        end
        ST_CHR_END: begin
          if (c == CH_SQUOTE) begin
            ea_v = 1'b1; ea.token_kind = KIND_CHR;
            text_length_next = sat_inc(text_length);
            ea.token_length = text_length_next;
            lex_state_next = ST_START;
          end else begin
            ea_v = 1'b1; ea.token_kind = KIND_UNDEF; redo = 1'b1;
          end
        end
        default: redo = 1'b1;
      endcase

      // Examine the byte as the start of a new token
      if (redo) begin
        lex_state_next = ST_START;
        eb.token_row    = line_count_next;
        eb.token_col    = column_count_next;
        eb.token_length = 16'd1;
        case (c) inside
          CH_NL: begin
            line_count_next   = sat_inc(line_count);
            column_count_next = '0;
          end
          CH_SPACE: ;
          CH_STAR, CH_SLASH, CH_EQ, CH_GT, CH_LT, CH_BANG, CH_PLUS, CH_MINUS,
          CH_AMP, CH_BAR, CH_DQUOTE, CH_SQUOTE, [CH_DIG0:CH_DIG9],
          [CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]: begin
            start_column_next = column_count_next;
            text_length_next  = (c == CH_DQUOTE) ? 16'd0 : 16'd1;
            case (c) inside
              CH_STAR:            lex_state_next = ST_MUL;
              CH_SLASH:           lex_state_next = ST_SLASH;
              CH_EQ:              lex_state_next = ST_EQ;
              CH_GT:              lex_state_next = ST_GT;
              CH_LT:              lex_state_next = ST_LT;
              CH_BANG:            lex_state_next = ST_NOT;
              CH_PLUS:            lex_state_next = ST_ADD;
              CH_MINUS:           lex_state_next = ST_SUB;
              CH_AMP:             lex_state_next = ST_AND;
              CH_BAR:             lex_state_next = ST_OR;
              CH_DQUOTE:          lex_state_next = ST_STR;
              CH_SQUOTE:          lex_state_next = ST_CHR;
              [CH_DIG0:CH_DIG9]:  lex_state_next = ST_INT;
              default:            lex_state_next = ST_ID;
            endcase
          end
          CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
          CH_SEMI, CH_COMMA: begin
            eb_v = 1'b1; eb.token_kind = KIND_SIGN;
          end
          default: begin
            eb_v = 1'b1; eb.token_kind = KIND_UNDEF;
          end
        endcase
      end
    end
    ea.last = !eb_v;
    eb.last = 1'b1;
  end

  assign push_n = {1'b0, ea_v} + {1'b0, eb_v};

  // Advance recogniser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state    <= ST_START;
      line_count   <= '0;
      column_count <= '0;
      start_column <= '0;
      text_length  <= '0;
    end else if (accept) begin
      lex_state    <= lex_state_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      start_column <= start_column_next;
      text_length  <= text_length_next;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      fill <= fill + FILL_W'(accept ? push_n : 2'd0) - FILL_W'(pop);
    end
  end

  // Write the byte's records in order
  always_ff @(posedge clk) begin
    if (accept) begin
      if (ea_v) begin
        queue[wr_ptr] <= ea;
        if (eb_v) queue[wr_ptr + PTR_W'(1)] <= eb;
      end else if (eb_v) begin
        queue[wr_ptr] <= eb;
      end
    end
  end

endmodule

@@ rtl/ctl_checker.sv @@
// Port-level checks for the C-style token lexer, bound to the top level.
// Depends on ctl_pkg.
module ctl_checker (
  input logic        clk,
  input logic        rst,
  input logic        src_valid,
  input logic        src_ready,
  input logic        src_end,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [2:0]  tok_kind,
  input logic [15:0] tok_length,
  input logic        tok_last
);
  import ctl_pkg::*;

  // Hold a stalled record
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("token record dropped while stalled");

  // Queue is empty straight after a reset cycle
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("token record present after reset");

  // End record carries zero length and closes its byte
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_kind == KIND_END |-> tok_length == 16'd0 && tok_last)
    else $error("malformed end record");

  // An end-of-source transfer always yields a record on the next cycle
  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_ready && src_end |=> tok_valid)
    else $error("end of source gave no record");
endmodule

bind c_style_token_lexer ctl_checker u_ctl_checker (
  .clk        (clk),
  .rst        (rst),
  .src_valid  (src.valid),
  .src_ready  (src.ready),
  .src_end    (src.data.end_of_input),
  .tok_valid  (tok.valid),
  .tok_ready  (tok.ready),
  .tok_kind   (tok.data.token_kind),
  .tok_length (tok.data.token_length),
  .tok_last   (tok.data.last)
);
